>>> hdl/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result kinds, character codes, the UTF-8 encoder and the hex digit decoder
// shared by the unescape unit.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // One byte causes at most 7 results (held surrogate, code, tail, error)
  localparam int unsigned MAX_RES = 8;
  localparam int unsigned IDX_W   = $clog2(MAX_RES);
  localparam int unsigned CNT_W   = IDX_W + 1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  // Characters of the JSON string syntax
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  // Control characters that the short escapes stand for
  localparam logic [7:0] CTRL_BS = 8'h08;
  localparam logic [7:0] CTRL_FF = 8'h0C;
  localparam logic [7:0] CTRL_LF = 8'h0A;
  localparam logic [7:0] CTRL_CR = 8'h0D;
  localparam logic [7:0] CTRL_HT = 8'h09;

  // Surrogate ranges
  localparam logic [15:0] HI_SUR_MIN = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;

  // One code point as UTF-8: byte 0 goes out first
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  // Hex digit decode result
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // Result list built for one input byte
  typedef struct packed {
    logic [CNT_W-1:0]              count;
    logic [MAX_RES-1:0][7:0]       bytes;
    kind_e [MAX_RES-1:0]           kinds;
  } res_list_t;

  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      // letters a-f and A-F share the low bits 1..6
      r.ok  = 1'b1;
      r.val = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return r;
  endfunction

endpackage

>>> hdl/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape decoder
// Holds the scan state and turns one registered input byte into the list of
// result items it causes; state advances when the list is handed on.
// ----------------------------------------------------------------------------
module jsu_decode (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        in_byte_i,
  input  logic              end_of_data_i,
  output jsu_pkg::res_list_t res_o
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_STR      = 4'd1,
    PH_ESC      = 4'd2,
    PH_HEX1     = 4'd3,
    PH_HELD     = 4'd4,
    PH_HELD_ESC = 4'd5,
    PH_HEX2     = 4'd6
  } phase_e;

  typedef enum logic [2:0] {
    M_NONE,
    M_RAW,
    M_CODE,
    M_CLOSE,
    M_ERROR
  } main_e;

  phase_e      phase_q, phase_d;
  logic [15:0] acc_q, acc_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] held_q, held_d;

  hex_t        hv;
  logic [15:0] acc_next;
  logic        pre_held;
  logic        str_b;
  logic        esc_b;
  logic        fresh;
  logic        go_idle;
  logic        end_tail;
  logic        end_held;
  main_e       main_mode;
  logic [7:0]  main_raw;
  logic [20:0] main_cp;
  utf8_t       pre_enc;
  utf8_t       main_enc;
  utf8_t       end_enc;
  res_list_t   lst;
  logic [CNT_W-1:0] n;

  assign hv       = hex_value(in_byte_i);
  assign acc_next = {acc_q[11:0], hv.val};

  // Work out next state and which result segments this byte produces
  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    pre_held  = 1'b0;
    str_b     = 1'b0;
    esc_b     = 1'b0;
    fresh     = 1'b0;
    go_idle   = 1'b0;
    main_mode = M_NONE;
    main_raw  = '0;
    main_cp   = '0;

    case (phase_q)
      PH_IDLE: begin
        if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_STR;
        end else begin
          main_mode = M_ERROR;
          go_idle   = 1'b1;
        end
      end
      PH_STR: str_b = 1'b1;
      PH_ESC: esc_b = 1'b1;
      PH_HEX1, PH_HEX2: begin
        if (!hv.ok) begin
          main_mode = M_ERROR;
          go_idle   = 1'b1;
        end else if (cnt_q != 2'd3) begin
          acc_d = acc_next;
          cnt_d = cnt_q + 2'd1;
        end else begin
          acc_d = '0;
          cnt_d = '0;
          if (phase_q == PH_HEX2 && acc_next >= LO_SUR_MIN && acc_next <= LO_SUR_MAX) begin
            // join the pair into one supplementary code point
            main_mode = M_CODE;
            main_cp   = SUPP_BASE + {1'b0, held_q[9:0], acc_next[9:0]};
            held_d    = '0;
            phase_d   = PH_STR;
          end else begin
            pre_held = (phase_q == PH_HEX2);
            held_d   = '0;
            fresh    = 1'b1;
          end
        end
      end
      PH_HELD: begin
        if (in_byte_i == CH_BSLASH) begin
          phase_d = PH_HELD_ESC;
        end else begin
          pre_held = 1'b1;
          held_d   = '0;
          str_b    = 1'b1;
        end
      end
      PH_HELD_ESC: begin
        if (in_byte_i == CH_U) begin
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = PH_HEX2;
        end else begin
          pre_held = 1'b1;
          held_d   = '0;
          esc_b    = 1'b1;
        end
      end
      default: begin
        main_mode = M_ERROR;
        go_idle   = 1'b1;
      end
    endcase

    // Plain string byte
    if (str_b) begin
      if (in_byte_i == CH_QUOTE) begin
        main_mode = M_CLOSE;
        go_idle   = 1'b1;
      end else if (in_byte_i == CH_BSLASH) begin
        phase_d = PH_ESC;
      end else begin
        main_mode = M_RAW;
        main_raw  = in_byte_i;
        phase_d   = PH_STR;
      end
    end

    // Escape letter
    if (esc_b) begin
      phase_d   = PH_STR;
      main_mode = M_RAW;
      case (in_byte_i)
        CH_QUOTE:  main_raw = CH_QUOTE;
        CH_BSLASH: main_raw = CH_BSLASH;
        CH_SLASH:  main_raw = CH_SLASH;
        CH_B:      main_raw = CTRL_BS;
        CH_F:      main_raw = CTRL_FF;
        CH_N:      main_raw = CTRL_LF;
        CH_R:      main_raw = CTRL_CR;
        CH_T:      main_raw = CTRL_HT;
        CH_U: begin
          main_mode = M_NONE;
          acc_d     = '0;
          cnt_d     = '0;
          phase_d   = PH_HEX1;
        end
        default: begin
          main_mode = M_ERROR;
          go_idle   = 1'b1;
        end
      endcase
    end

    // Completed code unit without a partner: hold a high surrogate, else emit
    if (fresh) begin
      if (acc_next >= HI_SUR_MIN && acc_next <= HI_SUR_MAX) begin
        held_d  = acc_next;
        phase_d = PH_HELD;
      end else begin
        main_mode = M_CODE;
        main_cp   = {5'd0, acc_next};
        phase_d   = PH_STR;
      end
    end

    if (go_idle) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      cnt_d   = '0;
      held_d  = '0;
    end

    // Buffer ends inside a string: flush a waiting surrogate, then error
    end_tail = end_of_data_i && (phase_d != PH_IDLE);
    end_held = end_tail && (phase_d == PH_HELD || phase_d == PH_HELD_ESC);
    if (end_tail) begin
      phase_d = PH_IDLE;
      acc_d   = '0;
      cnt_d   = '0;
      held_d  = '0;
    end
  end

  assign pre_enc  = utf8_encode({5'd0, held_q});
  assign main_enc = utf8_encode(main_cp);

  // The surrogate flushed at end of data is the one held after this byte
  always_comb begin
    logic [15:0] tail_held;
    tail_held = held_q;
    if (fresh) begin
      tail_held = acc_next;
    end
    end_enc = utf8_encode({5'd0, tail_held});
  end

  // Lay the segments out in order
  always_comb begin
    lst = '0;
    n   = '0;
    if (pre_held) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < pre_enc.len) begin
          lst.bytes[n[IDX_W-1:0]] = pre_enc.b[i];
          lst.kinds[n[IDX_W-1:0]] = KIND_DATA;
          n = n + 1'b1;
        end
      end
    end
    case (main_mode)
      M_RAW: begin
        lst.bytes[n[IDX_W-1:0]] = main_raw;
        lst.kinds[n[IDX_W-1:0]] = KIND_DATA;
        n = n + 1'b1;
      end
      M_CODE: begin
        for (int i = 0; i < 4; i++) begin
          if (3'(i) < main_enc.len) begin
            lst.bytes[n[IDX_W-1:0]] = main_enc.b[i];
            lst.kinds[n[IDX_W-1:0]] = KIND_DATA;
            n = n + 1'b1;
          end
        end
      end
      M_CLOSE: begin
        lst.bytes[n[IDX_W-1:0]] = '0;
        lst.kinds[n[IDX_W-1:0]] = KIND_CLOSE;
        n = n + 1'b1;
      end
      M_ERROR: begin
        lst.bytes[n[IDX_W-1:0]] = '0;
        lst.kinds[n[IDX_W-1:0]] = KIND_ERROR;
        n = n + 1'b1;
      end
      default: ;
    endcase
    if (end_held) begin
      for (int i = 0; i < 4; i++) begin
        if (3'(i) < end_enc.len) begin
          lst.bytes[n[IDX_W-1:0]] = end_enc.b[i];
          lst.kinds[n[IDX_W-1:0]] = KIND_DATA;
          n = n + 1'b1;
        end
      end
    end
    if (end_tail) begin
      lst.bytes[n[IDX_W-1:0]] = '0;
      lst.kinds[n[IDX_W-1:0]] = KIND_ERROR;
      n = n + 1'b1;
    end
    lst.count = n;
  end

  assign res_o = lst;

  // Advance scan state when the byte's results are handed on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
      held_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      held_q  <= held_d;
    end
  end

endmodule

>>> hdl/jsu_result_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape result buffer
// Registers the result list of one byte and hands it out one transfer at a
// time; takes the next list when empty or as the last entry leaves.
// ----------------------------------------------------------------------------
module jsu_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  jsu_pkg::res_list_t res_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic [1:0]         kind_o,
  output logic               last_o
);
  import jsu_pkg::*;

  logic [MAX_RES-1:0][7:0] bytes_q;
  kind_e [MAX_RES-1:0]     kinds_q;
  logic [CNT_W-1:0]        count_q;
  logic [IDX_W-1:0]        rd_q;
  logic                    is_last;
  logic                    pop;

  assign out_valid_o = (count_q != '0);
  assign is_last     = ({1'b0, rd_q} == count_q - 1'b1);
  assign pop         = out_valid_o && out_ready_i;
  assign can_load_o  = !out_valid_o || (pop && is_last);

  assign out_byte_o = bytes_q[rd_q];
  assign kind_o     = kinds_q[rd_q];
  assign last_o     = is_last;

  // Hold the list payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= res_i.bytes;
      kinds_q <= res_i.kinds;
    end
  end

  // Track fill and read position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      rd_q    <= '0;
    end else if (load_i) begin
      count_q <= res_i.count;
      rd_q    <= '0;
    end else if (pop) begin
      if (is_last) begin
        count_q <= '0;
        rd_q    <= '0;
      end else begin
        rd_q <= rd_q + 1'b1;
      end
    end
  end

endmodule

>>> hdl/json_string_unescape_utf8_unit.sv
`timescale 1ns / 1ps
// A result passes the input register, then the result buffer, before it leaves.
// Throughput: one input byte per cycle while each byte yields at most one result
// and out_ready_i is high; a byte with several results holds the single output port
// until they leave; the output port, one result per cycle when ready, sets the rate.
// Reset (rst_ni low, asynchronous) empties both stages and returns the scanner
// to idle, waiting for an opening quote.
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Input register, decoder with scan state, and result buffer.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);
  import jsu_pkg::*;

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_eod_q;
  logic       can_load;
  logic       advance;
  res_list_t  res;

  assign advance    = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || advance;

  // Input register: hold the byte until its results are taken in
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
      in_eod_q  <= end_of_data_i;
    end
  end

  jsu_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (advance),
    .in_byte_i     (in_byte_q),
    .end_of_data_i (in_eod_q),
    .res_o         (res)
  );

  jsu_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (res),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .kind_o      (kind_o),
    .last_o      (last_o)
  );

endmodule

>>> hdl/jsu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape port checker
// Watches the top-level ports for result ordering and payload rules.
// ----------------------------------------------------------------------------
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] kind_i,
  input logic       last_i
);
  import jsu_pkg::*;

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i)
      && $stable(kind_i) && $stable(last_i))
    else $error("result changed while stalled");

  // Close and error results end the list of their input byte
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_DATA) |-> last_i)
    else $error("status result not last");

  // Status results carry a zero byte
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_DATA) |-> out_byte_i == 8'd0)
    else $error("status result with nonzero byte");

  // Only defined kinds appear
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (kind_i == KIND_DATA || kind_i == KIND_CLOSE
      || kind_i == KIND_ERROR))
    else $error("undefined result kind");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_i  (out_byte_o),
  .kind_i      (kind_o),
  .last_i      (last_o)
);
